### sv/tet_face_adjacency_table_macros.svh
// ---------------------------------------------------------------------------
// tet face adjacency table assertion macros
// assertion wrappers that compile away in synthesis builds
// ---------------------------------------------------------------------------
`ifndef TET_FACE_ADJACENCY_TABLE_MACROS_SVH
`define TET_FACE_ADJACENCY_TABLE_MACROS_SVH
`ifndef SYNTH
`define TFAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TFAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFAT_ASSERT_IMP(lbl, ante, cons, msg)
`define TFAT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### sv/tfat_pkg.sv
// ---------------------------------------------------------------------------
// tfat_pkg
// shared types and constants of the tet face adjacency table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tfat_pkg;
  localparam int unsigned TableDepth = 8192;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned VertW      = 20;
  localparam int unsigned LimW       = 7;
  localparam logic [LimW-1:0] LimReset = 7'd16;
  localparam logic [LimW-1:0] LimMax   = 7'd64;
  localparam logic [LimW-1:0] LimMin   = 7'd1;
  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic             used;
    logic             has_nb;
    logic [VertW-1:0] ka;
    logic [VertW-1:0] kb;
    logic [VertW-1:0] kc;
    logic [VertW-1:0] owner;
    logic [VertW-1:0] nb;
  } entry_t;

  typedef struct packed {
    logic [AddrW-1:0] slot;
    entry_t           ent;
    logic             full;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FACE, ST_RD, ST_CHK, ST_EMIT
  } state_e;
endpackage
`default_nettype wire

### sv/tfat_ram.sv
// ---------------------------------------------------------------------------
// tfat_ram
// single port synchronous ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tfat_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### sv/tet_face_adjacency_table.sv
// ---------------------------------------------------------------------------
// tet face adjacency table
// hashes the four faces of each tetrahedron into a slot table with linear
// probing and records owner and neighbor tets; read command reports a slot
// ---------------------------------------------------------------------------
// channel   direction  handshake
// in        input      in_valid_i / in_ready_o
// out       output     out_valid_o / out_ready_i
// cfg       input      apb psel penable pwrite, pready tied high
//
// add: accept, then per face the FACE, RD, CHK and EMIT states, with a further
// RD and CHK pass per extra probe
// read: accept, then the RD, CHK and EMIT states to the output register
// after reset a clearing pass writes all 8192 slots before any word is taken
// output register lets the next word in while the last result waits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tet_face_adjacency_table_macros.svh"
module tet_face_adjacency_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [12:0] slot_i,
  input  wire logic [19:0] tet_id_i,
  input  wire logic [19:0] vert_0_i,
  input  wire logic [19:0] vert_1_i,
  input  wire logic [19:0] vert_2_i,
  input  wire logic [19:0] vert_3_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [12:0]      slot_index_o,
  output logic [19:0]      face_a_o,
  output logic [19:0]      face_b_o,
  output logic [19:0]      face_c_o,
  output logic [19:0]      owner_tet_o,
  output logic [19:0]      neighbor_tet_o,
  output logic             has_neighbor_o,
  output logic             is_boundary_o,
  output logic             slot_used_o,
  output logic             table_full_o,
  output logic             last_o
);
  import tfat_pkg::*;

  state_e           state_q, state_d;
  logic [LimW-1:0]  plim_q;
  logic [AddrW-1:0] addr_q, addr_d, home_q, home_d;
  logic [LimW-1:0]  cnt_q, cnt_d;
  logic [1:0]       face_q, face_d;
  logic             cmd_q;
  logic [VertW-1:0] tet_q, v0_q, v1_q, v2_q, v3_q;
  logic [VertW-1:0] fa, fb, fc;
  logic [VertW-1:0] fa_q, fb_q, fc_q;
  logic             face_ld;
  result_t          res_q, res_d;
  result_t          out_q;
  logic             out_valid_q, out_ld;
  logic             we;
  entry_t           wdata, rdata;
  logic [AddrW-1:0] ram_addr;
  logic [LimW-1:0]  lim;
  logic             match, in_acc;

  assign pready = 1'b1;
  assign prdata = {25'd0, plim_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plim_q <= LimReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      plim_q <= pwdata[LimW-1:0];
    end
  end

  assign lim = (plim_q < LimMin) ? LimMin : ((plim_q > LimMax) ? LimMax : plim_q);

  always_comb begin
    case (face_q)
      2'd0:    begin fa = v0_q; fb = v2_q; fc = v1_q; end
      2'd1:    begin fa = v3_q; fb = v0_q; fc = v1_q; end
      2'd2:    begin fa = v3_q; fb = v2_q; fc = v0_q; end
      default: begin fa = v2_q; fb = v3_q; fc = v1_q; end
    endcase
  end

  assign match = (rdata.ka == fa_q && rdata.kb == fb_q && rdata.kc == fc_q) ||
                 (rdata.ka == fa_q && rdata.kb == fc_q && rdata.kc == fb_q) ||
                 (rdata.ka == fb_q && rdata.kb == fa_q && rdata.kc == fc_q) ||
                 (rdata.ka == fb_q && rdata.kb == fc_q && rdata.kc == fa_q) ||
                 (rdata.ka == fc_q && rdata.kb == fa_q && rdata.kc == fb_q) ||
                 (rdata.ka == fc_q && rdata.kb == fb_q && rdata.kc == fa_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ram_addr   = addr_q;

  tfat_ram #(.Depth(TableDepth), .Width($bits(entry_t))) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    home_d  = home_q;
    cnt_d   = cnt_q;
    face_d  = face_q;
    res_d   = res_q;
    we      = 1'b0;
    wdata   = '0;
    out_ld  = 1'b0;
    face_ld = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we     = 1'b1;
        addr_d = addr_q + 1'b1;
        if (&addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          face_d = 2'd0;
          if (command_i == CmdRead) begin
            addr_d  = slot_i;
            state_d = ST_RD;
          end else begin
            state_d = ST_FACE;
          end
        end
      end
      ST_FACE: begin
        face_ld = 1'b1;
        addr_d  = fa[AddrW-1:0] ^ fb[AddrW-1:0] ^ fc[AddrW-1:0];
        home_d  = addr_d;
        cnt_d   = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        res_d.slot = addr_q;
        res_d.full = 1'b0;
        res_d.last = (cmd_q == CmdRead) || (face_q == 2'd3);
        state_d    = ST_EMIT;
        if (cmd_q == CmdRead) begin
          res_d.ent = rdata.used ? rdata : '0;
          if (rdata.used && !rdata.has_nb) begin
            res_d.ent.nb = '0;
          end
        end else if (!rdata.used) begin
          we           = 1'b1;
          wdata.used   = 1'b1;
          wdata.has_nb = 1'b0;
          wdata.ka     = fa_q;
          wdata.kb     = fb_q;
          wdata.kc     = fc_q;
          wdata.owner  = tet_q;
          wdata.nb     = '0;
          res_d.ent    = wdata;
        end else if (match) begin
          we           = 1'b1;
          wdata        = rdata;
          wdata.has_nb = 1'b1;
          wdata.nb     = tet_q;
          res_d.ent    = wdata;
        end else if (cnt_q + 1'b1 == lim) begin
          res_d.slot   = home_q;
          res_d.ent    = '0;
          res_d.ent.ka = fa_q;
          res_d.ent.kb = fb_q;
          res_d.ent.kc = fc_q;
          res_d.full   = 1'b1;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          addr_d  = addr_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld = 1'b1;
          if (res_q.last) begin
            state_d = ST_IDLE;
          end else begin
            face_d  = face_q + 1'b1;
            state_d = ST_FACE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      cnt_q       <= '0;
      face_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      face_q  <= face_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    home_q <= home_d;
    res_q  <= res_d;
    if (in_acc) begin
      cmd_q <= command_i;
      tet_q <= tet_id_i;
      v0_q  <= vert_0_i;
      v1_q  <= vert_1_i;
      v2_q  <= vert_2_i;
      v3_q  <= vert_3_i;
    end
    if (face_ld) begin
      fa_q <= fa;
      fb_q <= fb;
      fc_q <= fc;
    end
    if (out_ld) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_index_o   = out_q.slot;
  assign face_a_o       = out_q.ent.ka;
  assign face_b_o       = out_q.ent.kb;
  assign face_c_o       = out_q.ent.kc;
  assign owner_tet_o    = out_q.ent.owner;
  assign neighbor_tet_o = out_q.ent.nb;
  assign has_neighbor_o = out_q.ent.has_nb;
  assign is_boundary_o  = out_q.ent.used && !out_q.ent.has_nb;
  assign slot_used_o    = out_q.ent.used;
  assign table_full_o   = out_q.full;
  assign last_o         = out_q.last;

  `TFAT_ASSERT_NXT(a_acc_busy, in_acc, state_q != ST_IDLE, "item taken but block idle")
  `TFAT_ASSERT_IMP(a_clr_wr, state_q == ST_CLEAR, we && !wdata.used, "clear pass lost")
  `TFAT_ASSERT_IMP(a_probe_cnt, state_q == ST_CHK && cmd_q == CmdAdd,
                   cnt_q < lim, "probe count past limit")
  `TFAT_ASSERT_IMP(a_emit_hold, state_q == ST_EMIT && out_valid_q && !out_ready_i,
                   !out_ld, "result overwritten")
endmodule
`default_nettype wire
